[rtl/jsar_pkg.sv]
// Shared types and constants of the JSON string-array recognizer.
package jsar_pkg;

  localparam int unsigned KIND_W = 4;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned CODE_W = 4;
  localparam int unsigned POS_W  = 21;
  localparam int unsigned MAX_W  = 21;

  localparam logic [MAX_W-1:0] MAX_TEXT_RESET = 21'd1048576;

  // Event kinds.
  localparam logic [KIND_W-1:0] EV_NONE       = 4'd0;
  localparam logic [KIND_W-1:0] EV_OBJ_BEGIN  = 4'd1;
  localparam logic [KIND_W-1:0] EV_KEY_CHAR   = 4'd2;
  localparam logic [KIND_W-1:0] EV_KEY_END    = 4'd3;
  localparam logic [KIND_W-1:0] EV_VAL_CHAR   = 4'd4;
  localparam logic [KIND_W-1:0] EV_PAIR_END   = 4'd5;
  localparam logic [KIND_W-1:0] EV_OBJ_END    = 4'd6;
  localparam logic [KIND_W-1:0] EV_SCRIPT_END = 4'd7;
  localparam logic [KIND_W-1:0] EV_ERROR      = 4'd8;

  // Error codes.
  localparam logic [CODE_W-1:0] ERR_NONE        = 4'd0;
  localparam logic [CODE_W-1:0] ERR_NOT_ARRAY   = 4'd1;
  localparam logic [CODE_W-1:0] ERR_NOT_OBJECT  = 4'd2;
  localparam logic [CODE_W-1:0] ERR_EXP_QUOTE   = 4'd3;
  localparam logic [CODE_W-1:0] ERR_EXP_COLON   = 4'd4;
  localparam logic [CODE_W-1:0] ERR_EXP_COMMA_BRACE   = 4'd5;
  localparam logic [CODE_W-1:0] ERR_EXP_COMMA_BRACKET = 4'd6;
  localparam logic [CODE_W-1:0] ERR_BAD_ESCAPE  = 4'd7;
  localparam logic [CODE_W-1:0] ERR_OPEN_ESCAPE = 4'd8;
  localparam logic [CODE_W-1:0] ERR_OPEN_STRING = 4'd9;
  localparam logic [CODE_W-1:0] ERR_TOO_LARGE   = 4'd10;

  // Characters of the grammar.
  localparam logic [CHAR_W-1:0] CH_LBRACKET  = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_RBRACKET  = 8'h5D;
  localparam logic [CHAR_W-1:0] CH_LBRACE    = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_RBRACE    = 8'h7D;
  localparam logic [CHAR_W-1:0] CH_COLON     = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_COMMA     = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_QUOTE     = 8'h22;
  localparam logic [CHAR_W-1:0] CH_BACKSLASH = 8'h5C;
  localparam logic [CHAR_W-1:0] CH_LF        = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR        = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

  typedef struct packed {
    logic [KIND_W-1:0] event_kind;
    logic [CHAR_W-1:0] decoded_char;
    logic [CODE_W-1:0] error_code;
    logic [POS_W-1:0]  error_line;
    logic [POS_W-1:0]  error_column;
    logic              last_of_run;
  } result_t;

  // Results of one input item: how many (0 to 2) and the two slots in order.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } step_t;

endpackage

[rtl/jsar_in_if.sv]
// Input channel: one text byte request with its flags.
interface jsar_in_if;
  logic                         valid;
  logic                         ready;
  logic [jsar_pkg::CHAR_W-1:0]  text_byte;
  logic                         has_byte;
  logic                         end_of_text;

  modport source (output valid, output text_byte, output has_byte, output end_of_text,
                  input ready);
  modport sink (input valid, input text_byte, input has_byte, input end_of_text,
                output ready);
endinterface

[rtl/jsar_out_if.sv]
// Output channel: one event request of the recognizer.
interface jsar_out_if;
  logic                         valid;
  logic                         ready;
  logic [jsar_pkg::KIND_W-1:0]  event_kind;
  logic [jsar_pkg::CHAR_W-1:0]  decoded_char;
  logic [jsar_pkg::CODE_W-1:0]  error_code;
  logic [jsar_pkg::POS_W-1:0]   error_line;
  logic [jsar_pkg::POS_W-1:0]   error_column;
  logic                         last_of_run;

  modport source (output valid, output event_kind, output decoded_char, output error_code,
                  output error_line, output error_column, output last_of_run,
                  input ready);
  modport sink (input valid, input event_kind, input decoded_char, input error_code,
                input error_line, input error_column, input last_of_run,
                output ready);
endinterface

[rtl/jsar_parser.sv]
// Parse state machine, position counters and size limit of the recognizer.
module jsar_parser #(
  parameter int unsigned POSITION_BITS = 21
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [jsar_pkg::MAX_W-1:0]   cfg_wdata_i,
  input  logic                         step_i,
  input  logic [jsar_pkg::CHAR_W-1:0]  text_byte_i,
  input  logic                         has_byte_i,
  input  logic                         end_of_text_i,
  output jsar_pkg::step_t              step_o
);

  typedef enum logic [3:0] {
    PH_OPEN, PH_FIRST, PH_OBJ, PH_OBJ_FIRST, PH_KEY_Q, PH_KEY, PH_KEY_ESC,
    PH_COLON, PH_VAL_Q, PH_VAL, PH_VAL_ESC, PH_AFTER_PAIR, PH_AFTER_OBJ,
    PH_DONE, PH_ERR
  } phase_e;

  localparam int unsigned EXT_W = (POSITION_BITS > jsar_pkg::POS_W) ? POSITION_BITS
                                                                    : jsar_pkg::POS_W;
  localparam int unsigned CMP_W = ((POSITION_BITS > jsar_pkg::MAX_W) ? POSITION_BITS
                                                                     : jsar_pkg::MAX_W) + 1;
  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
  localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

  phase_e                     phase_q, phase_d, phase_mid;
  logic [POSITION_BITS-1:0]   line_q, line_d;
  logic [POSITION_BITS-1:0]   col_q, col_d;
  logic [POSITION_BITS-1:0]   bytes_q, bytes_d;
  logic [jsar_pkg::MAX_W-1:0] max_q;

  logic              live, over_limit, is_ws;
  logic              byte_hit, fin_hit;
  jsar_pkg::result_t byte_res, fin_res;

  function automatic logic [jsar_pkg::POS_W-1:0] pos_out(input logic [POSITION_BITS-1:0] v);
    logic [EXT_W-1:0] e;
    e = EXT_W'(v);
    return e[jsar_pkg::POS_W-1:0];
  endfunction

  function automatic jsar_pkg::result_t make_ev(input logic [jsar_pkg::KIND_W-1:0] kind,
                                                input logic [jsar_pkg::CHAR_W-1:0] ch);
    jsar_pkg::result_t r;
    r = '0;
    r.event_kind   = kind;
    r.decoded_char = ch;
    return r;
  endfunction

  function automatic jsar_pkg::result_t make_err(input logic [jsar_pkg::CODE_W-1:0] code,
                                                 input logic [POSITION_BITS-1:0] ln,
                                                 input logic [POSITION_BITS-1:0] cl);
    jsar_pkg::result_t r;
    r = '0;
    r.event_kind   = jsar_pkg::EV_ERROR;
    r.error_code   = code;
    r.error_line   = pos_out(ln);
    r.error_column = pos_out(cl);
    return r;
  endfunction

  // Error that an end of text raises in each phase.
  function automatic logic [jsar_pkg::CODE_W-1:0] end_code(input phase_e p);
    logic [jsar_pkg::CODE_W-1:0] c;
    unique case (p)
      PH_OPEN:                     c = jsar_pkg::ERR_NOT_ARRAY;
      PH_FIRST, PH_OBJ:            c = jsar_pkg::ERR_NOT_OBJECT;
      PH_OBJ_FIRST, PH_KEY_Q,
      PH_VAL_Q:                    c = jsar_pkg::ERR_EXP_QUOTE;
      PH_KEY, PH_VAL:              c = jsar_pkg::ERR_OPEN_STRING;
      PH_KEY_ESC, PH_VAL_ESC:      c = jsar_pkg::ERR_OPEN_ESCAPE;
      PH_COLON:                    c = jsar_pkg::ERR_EXP_COLON;
      PH_AFTER_PAIR:               c = jsar_pkg::ERR_EXP_COMMA_BRACE;
      PH_AFTER_OBJ:                c = jsar_pkg::ERR_EXP_COMMA_BRACKET;
      default:                     c = jsar_pkg::ERR_NONE;
    endcase
    return c;
  endfunction

  assign live       = (phase_q != PH_DONE) && (phase_q != PH_ERR);
  assign over_limit = (CMP_W'(bytes_q) + CMP_W'(1)) > CMP_W'(max_q);
  assign is_ws      = (text_byte_i == jsar_pkg::CH_SPACE) || (text_byte_i == jsar_pkg::CH_TAB)
                   || (text_byte_i == jsar_pkg::CH_CR) || (text_byte_i == jsar_pkg::CH_LF);

  always_comb begin
    phase_mid = phase_q;
    line_d    = line_q;
    col_d     = col_q;
    bytes_d   = bytes_q;
    byte_hit  = 1'b0;
    byte_res  = '0;
    fin_hit   = 1'b0;
    fin_res   = '0;

    if (step_i && has_byte_i && live) begin
      if (over_limit) begin
        // The byte that breaks the limit is not parsed and not counted.
        byte_hit  = 1'b1;
        byte_res  = make_err(jsar_pkg::ERR_TOO_LARGE, line_q, col_q);
        phase_mid = PH_ERR;
      end else begin
        if (phase_q == PH_KEY || phase_q == PH_VAL) begin
          if (text_byte_i == jsar_pkg::CH_QUOTE) begin
            byte_hit  = 1'b1;
            byte_res  = make_ev((phase_q == PH_KEY) ? jsar_pkg::EV_KEY_END
                                                    : jsar_pkg::EV_PAIR_END, '0);
            phase_mid = (phase_q == PH_KEY) ? PH_COLON : PH_AFTER_PAIR;
          end else if (text_byte_i == jsar_pkg::CH_BACKSLASH) begin
            phase_mid = (phase_q == PH_KEY) ? PH_KEY_ESC : PH_VAL_ESC;
          end else begin
            byte_hit = 1'b1;
            byte_res = make_ev((phase_q == PH_KEY) ? jsar_pkg::EV_KEY_CHAR
                                                   : jsar_pkg::EV_VAL_CHAR, text_byte_i);
          end
        end else if (phase_q == PH_KEY_ESC || phase_q == PH_VAL_ESC) begin
          byte_hit = 1'b1;
          if (text_byte_i == jsar_pkg::CH_QUOTE || text_byte_i == jsar_pkg::CH_BACKSLASH) begin
            byte_res  = make_ev((phase_q == PH_KEY_ESC) ? jsar_pkg::EV_KEY_CHAR
                                                        : jsar_pkg::EV_VAL_CHAR, text_byte_i);
            phase_mid = (phase_q == PH_KEY_ESC) ? PH_KEY : PH_VAL;
          end else begin
            byte_res  = make_err(jsar_pkg::ERR_BAD_ESCAPE, line_q, col_q);
            phase_mid = PH_ERR;
          end
        end else if (!is_ws) begin
          unique case (phase_q)
            PH_OPEN: begin
              if (text_byte_i == jsar_pkg::CH_LBRACKET) begin
                phase_mid = PH_FIRST;
              end else begin
                byte_hit  = 1'b1;
                byte_res  = make_err(jsar_pkg::ERR_NOT_ARRAY, line_q, col_q);
                phase_mid = PH_ERR;
              end
            end
            PH_FIRST, PH_OBJ: begin
              byte_hit = 1'b1;
              if (text_byte_i == jsar_pkg::CH_LBRACE) begin
                byte_res  = make_ev(jsar_pkg::EV_OBJ_BEGIN, '0);
                phase_mid = PH_OBJ_FIRST;
              end else if (phase_q == PH_FIRST && text_byte_i == jsar_pkg::CH_RBRACKET) begin
                byte_res  = make_ev(jsar_pkg::EV_SCRIPT_END, '0);
                phase_mid = PH_DONE;
              end else begin
                byte_res  = make_err(jsar_pkg::ERR_NOT_OBJECT, line_q, col_q);
                phase_mid = PH_ERR;
              end
            end
            PH_OBJ_FIRST, PH_KEY_Q: begin
              if (text_byte_i == jsar_pkg::CH_QUOTE) begin
                phase_mid = PH_KEY;
              end else if (phase_q == PH_OBJ_FIRST && text_byte_i == jsar_pkg::CH_RBRACE) begin
                byte_hit  = 1'b1;
                byte_res  = make_ev(jsar_pkg::EV_OBJ_END, '0);
                phase_mid = PH_AFTER_OBJ;
              end else begin
                byte_hit  = 1'b1;
                byte_res  = make_err(jsar_pkg::ERR_EXP_QUOTE, line_q, col_q);
                phase_mid = PH_ERR;
              end
            end
            PH_COLON: begin
              if (text_byte_i == jsar_pkg::CH_COLON) begin
                phase_mid = PH_VAL_Q;
              end else begin
                byte_hit  = 1'b1;
                byte_res  = make_err(jsar_pkg::ERR_EXP_COLON, line_q, col_q);
                phase_mid = PH_ERR;
              end
            end
            PH_VAL_Q: begin
              if (text_byte_i == jsar_pkg::CH_QUOTE) begin
                phase_mid = PH_VAL;
              end else begin
                byte_hit  = 1'b1;
                byte_res  = make_err(jsar_pkg::ERR_EXP_QUOTE, line_q, col_q);
                phase_mid = PH_ERR;
              end
            end
            PH_AFTER_PAIR: begin
              if (text_byte_i == jsar_pkg::CH_COMMA) begin
                phase_mid = PH_KEY_Q;
              end else if (text_byte_i == jsar_pkg::CH_RBRACE) begin
                byte_hit  = 1'b1;
                byte_res  = make_ev(jsar_pkg::EV_OBJ_END, '0);
                phase_mid = PH_AFTER_OBJ;
              end else begin
                byte_hit  = 1'b1;
                byte_res  = make_err(jsar_pkg::ERR_EXP_COMMA_BRACE, line_q, col_q);
                phase_mid = PH_ERR;
              end
            end
            PH_AFTER_OBJ: begin
              if (text_byte_i == jsar_pkg::CH_COMMA) begin
                phase_mid = PH_OBJ;
              end else if (text_byte_i == jsar_pkg::CH_RBRACKET) begin
                byte_hit  = 1'b1;
                byte_res  = make_ev(jsar_pkg::EV_SCRIPT_END, '0);
                phase_mid = PH_DONE;
              end else begin
                byte_hit  = 1'b1;
                byte_res  = make_err(jsar_pkg::ERR_EXP_COMMA_BRACKET, line_q, col_q);
                phase_mid = PH_ERR;
              end
            end
            default: begin
            end
          endcase
        end

        // Every parsed byte moves the position (saturating at its maximum), whatever it caused.
        if (bytes_q != POS_MAX) begin
          bytes_d = bytes_q + POS_ONE;
        end
        if (text_byte_i == jsar_pkg::CH_LF) begin
          if (line_q != POS_MAX) begin
            line_d = line_q + POS_ONE;
          end
          col_d = POS_ONE;
        end else if (col_q != POS_MAX) begin
          col_d = col_q + POS_ONE;
        end
      end
    end

    // An end marker is judged against the phase the byte left behind.
    phase_d = phase_mid;
    if (step_i && end_of_text_i && phase_mid != PH_DONE && phase_mid != PH_ERR) begin
      fin_hit = 1'b1;
      fin_res = make_err(end_code(phase_mid), line_d, col_d);
      phase_d = PH_ERR;
    end
  end

  always_comb begin
    step_o       = '0;
    step_o.count = {1'b0, byte_hit} + {1'b0, fin_hit};
    if (byte_hit) begin
      step_o.first             = byte_res;
      step_o.first.last_of_run = !fin_hit;
      step_o.second            = fin_res;
      step_o.second.last_of_run = 1'b1;
    end else begin
      step_o.first             = fin_res;
      step_o.first.last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_OPEN;
      line_q  <= POS_ONE;
      col_q   <= POS_ONE;
      bytes_q <= '0;
      max_q   <= jsar_pkg::MAX_TEXT_RESET;
    end else begin
      phase_q <= phase_d;
      line_q  <= line_d;
      col_q   <= col_d;
      bytes_q <= bytes_d;
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
    end
  end

endmodule

[rtl/jsar_result_fifo.sv]
// Four-entry result queue that takes up to two results a cycle and gives one.
module jsar_result_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  jsar_pkg::step_t   push_i,
  input  logic              pop_i,
  output logic              room_o,
  output logic              valid_o,
  output jsar_pkg::result_t data_o
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;

  jsar_pkg::result_t mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              do_pop;

  // Room for a full pair keeps the producer free of any look at the count.
  assign room_o  = count_q <= CNT_W'(DEPTH - 2);
  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q + PTR_W'(push_i.count);
    rd_ptr_d = rd_ptr_q + PTR_W'(do_pop);
    count_d  = count_q + CNT_W'(push_i.count) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_q + PTR_W'(1)] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

[rtl/json_string_array_recognizer.sv]
// Top level of the JSON string-array recognizer.
//
//   channel   direction  payload                                          size
//   in_i      sink       text_byte, has_byte, end_of_text                 10 bits
//   out_o     source     event_kind, decoded_char, error_code,            59 bits
//                        error_line, error_column, last_of_run
//   cfg       write      cfg_wdata_i = max_text_bytes (cfg_we_i strobe)   21 bits
//
// One input request is taken per cycle while in_i.ready is high; its results
// are registered into a four-entry queue and leave it one per cycle while
// out_o.ready is high. in_i.ready is low only while the queue holds three or
// more results, as when out_o stalls or requests give two results each.
// Reset restarts parse state, positions, byte count, queue; limit = 1048576.
module json_string_array_recognizer #(
  parameter int unsigned POSITION_BITS = 21
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [jsar_pkg::MAX_W-1:0] cfg_wdata_i,
  jsar_in_if.sink                    in_i,
  jsar_out_if.source                 out_o
);

  logic              step;
  logic              room;
  jsar_pkg::step_t   step_res;
  jsar_pkg::result_t head;

  assign in_i.ready = room;
  assign step       = in_i.valid && room;

  jsar_parser #(
    .POSITION_BITS (POSITION_BITS)
  ) u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .step_i        (step),
    .text_byte_i   (in_i.text_byte),
    .has_byte_i    (in_i.has_byte),
    .end_of_text_i (in_i.end_of_text),
    .step_o        (step_res)
  );

  jsar_result_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (step_res),
    .pop_i   (out_o.ready),
    .room_o  (room),
    .valid_o (out_o.valid),
    .data_o  (head)
  );

  assign out_o.event_kind   = head.event_kind;
  assign out_o.decoded_char = head.decoded_char;
  assign out_o.error_code   = head.error_code;
  assign out_o.error_line   = head.error_line;
  assign out_o.error_column = head.error_column;
  assign out_o.last_of_run  = head.last_of_run;

endmodule

[rtl/jsar_checker.sv]
// Port-level assertions of the recognizer and their bind to the top level.
module jsar_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [jsar_pkg::KIND_W-1:0] event_kind,
  input logic [jsar_pkg::CHAR_W-1:0] decoded_char,
  input logic [jsar_pkg::CODE_W-1:0] error_code,
  input logic [jsar_pkg::POS_W-1:0]  error_line,
  input logic [jsar_pkg::POS_W-1:0]  error_column,
  input logic                        last_of_run
);

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(event_kind) && $stable(decoded_char)
      && $stable(error_code) && $stable(error_line) && $stable(error_column)
      && $stable(last_of_run))
    else $error("result changed while stalled");

  // An error ends parsing, so it is always the last result of its request.
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && event_kind == jsar_pkg::EV_ERROR |-> last_of_run)
    else $error("error event not last of run");

  // An error carries a real code.
  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && event_kind == jsar_pkg::EV_ERROR |-> error_code != jsar_pkg::ERR_NONE)
    else $error("error event without code");

  // Only character events carry a character, only errors a code and a position.
  a_clean_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && event_kind != jsar_pkg::EV_ERROR |->
      error_code == '0 && error_line == '0 && error_column == '0
      && (event_kind == jsar_pkg::EV_KEY_CHAR || event_kind == jsar_pkg::EV_VAL_CHAR
          || decoded_char == '0))
    else $error("stray field in non-error event");

endmodule

bind json_string_array_recognizer jsar_checker u_jsar_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid    (out_o.valid),
  .out_ready    (out_o.ready),
  .event_kind   (out_o.event_kind),
  .decoded_char (out_o.decoded_char),
  .error_code   (out_o.error_code),
  .error_line   (out_o.error_line),
  .error_column (out_o.error_column),
  .last_of_run  (out_o.last_of_run)
);
